FILE: hdl/bsfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsfd_pkg;

  // Dividend width of the index dividers (covers cols + block_cols - 1)
  localparam int DIV_W = 17;
  localparam int DVS_W = 13;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_COLS       = 2'd0,
    CFG_BLOCK_ROWS = 2'd1,
    CFG_BLOCK_COLS = 2'd2
  } cfg_idx_t;

  localparam logic [15:0] HALF_QNAN = 16'h7E00;
  localparam logic [15:0] HALF_INF  = 16'h7C00;

  // Item fields that ride alongside the divider pipeline
  typedef struct packed {
    logic       action;
    logic [11:0] scale_index;
    logic [7:0] scale_code;
    logic [7:0] weight_code;
  } side_t;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_DEQUANT = 1'b1;

  // E4M3 weight times 2^(scale-127), rounded to binary16 (nearest even)
  function automatic logic [15:0] fp8_to_half(input logic [7:0] w, input logic [7:0] sc);
    logic              sgn;
    logic [3:0]        ex;
    logic [2:0]        mn;
    logic [3:0]        m;
    logic signed [9:0] e;
    logic signed [9:0] p;
    logic signed [9:0] sh;
    logic [9:0]        d;
    logic [1:0]        msb;
    logic [15:0]       mant;
    logic [4:0]        rem;
    logic [4:0]        hlf;
    logic [15:0]       res;
    sgn = w[7];
    ex  = w[6:3];
    mn  = w[2:0];
    if (ex == 4'd0) begin
      m = {1'b0, mn};
      e = -10'sd9;
    end else begin
      m = {1'b1, mn};
      e = $signed({6'd0, ex}) - 10'sd10;
    end
    e = e + $signed({2'b00, sc}) - 10'sd127;
    if (m[3])      msb = 2'd3;
    else if (m[2]) msb = 2'd2;
    else if (m[1]) msb = 2'd1;
    else           msb = 2'd0;
    p  = e + $signed({8'd0, msb});
    sh = e + 10'sd24;
    mant = 16'd0;
    rem  = 5'd0;
    hlf  = 5'd0;
    d    = 10'd0;
    if (sc == 8'hFF || (ex == 4'hF && mn == 3'h7)) begin
      res = HALF_QNAN;
    end else if (m == 4'd0) begin
      res = {sgn, 15'd0};
    end else if (p > 10'sd15) begin
      res = {sgn, 15'd0} | HALF_INF;
    end else if (p >= -10'sd14) begin
      // hidden bit lands on the exponent field, giving the bias of 15
      mant = 16'({12'd0, m}) << (4'd10 - {2'd0, msb});
      res  = {sgn, 15'd0} | ((16'(p + 10'sd14) << 10) + mant);
    end else begin
      // subnormal range
      if (!sh[9]) begin
        mant = 16'({12'd0, m}) << sh[3:0];
      end else begin
        d = 10'(-sh);
        if (d >= 10'd6) begin
          mant = 16'd0;
        end else begin
          rem  = {1'b0, m} & ((5'd1 << d[2:0]) - 5'd1);
          hlf  = 5'd1 << (d[2:0] - 3'd1);
          mant = 16'({1'b0, m} >> d[2:0]);
          if (rem > hlf || (rem == hlf && mant[0])) mant = mant + 16'd1;
        end
      end
      res = {sgn, 15'd0} | mant;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bsfd_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage
module bsfd_div
  import bsfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic      [DIV_W-1:0] quotient
);

  logic [DVS_W-1:0] rem_r [DIV_W];
  logic [DIV_W-1:0] nq_r  [DIV_W];

  for (genvar s = 0; s < DIV_W; s++) begin : g_stage
    logic [DVS_W-1:0] rem_in;
    logic [DIV_W-1:0] nq_in;
    logic [DVS_W:0]   trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = dividend;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign nq_in  = nq_r[s-1];
    end

    // shift in next dividend bit, subtract when it fits
    assign trial = {rem_in, nq_in[DIV_W-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];
        nq_r[s]  <= {nq_in[DIV_W-2:0], ge};
      end
    end
  end

  assign quotient = nq_r[DIV_W-1];

endmodule

`default_nettype wire

FILE: hdl/block_scaled_fp8_dequant_fp16_core.sv
// Block-scaled FP8 dequantizer: E4M3 weight codes times E8M0 block scales,
// rounded to IEEE binary16.
// Input channel (in_valid / in_stall): action 0 writes scale_code into the
// scale store at scale_index, action 1 dequantizes weight_code at row/col.
// Result channel (out_valid / out_stall): one item per dequant item, none
// per load item, in input order.
// Configuration (cfg_we / cfg_index / cfg_wdata): cols, block_rows,
// block_cols; write only while no item is in flight.
// Pipeline: 20 register stages (17 divider stages that resolve one quotient
// bit each, index multiply, scale store read, rounding); the first loads at
// the accepting edge.
// Throughput: one item per cycle while the result side does not stall.
// A stall on the result side freezes the whole pipeline and raises in_stall.
// Reset clears the pipeline valids and sets cols to 1, block_rows to 1 and
// block_cols to 32; the scale store is not cleared and must be loaded before it is read.
`timescale 1ns / 1ps
`default_nettype none

module block_scaled_fp8_dequant_fp16_core
  import bsfd_pkg::*;
#(
  parameter int SCALE_DEPTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [11:0] in_scale_index,
  input  wire logic [7:0]  in_scale_code,
  input  wire logic [15:0] in_row,
  input  wire logic [15:0] in_col,
  input  wire logic [7:0]  in_weight_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_half_bits,
  output logic             out_out_of_range
);

  localparam int AW = (SCALE_DEPTH > 1) ? $clog2(SCALE_DEPTH) : 1;
  localparam int IW = 33;

  // Configuration registers
  logic [15:0]      cols_r;
  logic [DVS_W-1:0] brows_r;
  logic [DVS_W-1:0] bcols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= 16'd1;
      brows_r <= DVS_W'(1);
      bcols_r <= DVS_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS:       cols_r  <= cfg_wdata;
        CFG_BLOCK_ROWS: brows_r <= cfg_wdata[DVS_W-1:0];
        CFG_BLOCK_COLS: bcols_r <= cfg_wdata[DVS_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero registers act as one
  logic [15:0]      kc;
  logic [DVS_W-1:0] br;
  logic [DVS_W-1:0] bc;
  assign kc = (cols_r  == '0) ? 16'd1 : cols_r;
  assign br = (brows_r == '0) ? DVS_W'(1) : brows_r;
  assign bc = (bcols_r == '0) ? DVS_W'(1) : bcols_r;

  // Global advance: the pipeline moves unless a result waits on the stall
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Dividers: row/br, col/bc, ceil(kc/bc)
  logic [DIV_W-1:0] q_row;
  logic [DIV_W-1:0] q_col;
  logic [DIV_W-1:0] q_sk;

  bsfd_div u_div_row (
    .clk(clk), .en(en), .dividend(DIV_W'(in_row)), .divisor(br), .quotient(q_row)
  );
  bsfd_div u_div_col (
    .clk(clk), .en(en), .dividend(DIV_W'(in_col)), .divisor(bc), .quotient(q_col)
  );
  bsfd_div u_div_sk (
    .clk(clk), .en(en),
    .dividend(DIV_W'(DIV_W'(kc) + DIV_W'(bc) - DIV_W'(1))),
    .divisor(bc), .quotient(q_sk)
  );

  // Side line that tracks the divider stages
  logic  vld_r [DIV_W];
  side_t sb_r  [DIV_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_W; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < DIV_W; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= '{action: in_action, scale_index: in_scale_index,
                   scale_code: in_scale_code, weight_code: in_weight_code};
      for (int s = 1; s < DIV_W; s++) sb_r[s] <= sb_r[s-1];
    end
  end

  // Index stage: row block times blocks per row plus column block
  logic          m_vld_r;
  side_t         m_sb_r;
  logic [IW-1:0] m_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= vld_r[DIV_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_sb_r  <= sb_r[DIV_W-1];
      m_idx_r <= IW'(q_row[15:0] * q_sk[15:0]) + IW'(q_col[15:0]);
    end
  end

  // Scale store access: loads write, dequant items read
  logic [7:0]    mem [SCALE_DEPTH];
  logic [7:0]    rd_r;
  logic          a_vld_r;
  logic          a_oor_r;
  logic [7:0]    a_w_r;
  logic          ld_ok;
  logic          rd_oor;
  logic [16:0]   si_ext;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  assign si_ext = 17'(m_sb_r.scale_index);
  assign ld_ok  = si_ext < 17'(SCALE_DEPTH);
  assign waddr  = si_ext[AW-1:0];
  assign rd_oor = m_idx_r >= IW'(SCALE_DEPTH);
  assign raddr  = m_idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (en && m_vld_r && m_sb_r.action == ACT_LOAD && ld_ok) begin
      mem[waddr] <= m_sb_r.scale_code;
    end
    if (en) begin
      rd_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= m_vld_r && m_sb_r.action == ACT_DEQUANT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_oor_r <= rd_oor;
      a_w_r   <= m_sb_r.weight_code;
    end
  end

  // Rounding and output register
  logic        out_valid_r;
  logic [15:0] out_half_r;
  logic        out_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_oor_r  <= a_oor_r;
      out_half_r <= a_oor_r ? 16'd0 : fp8_to_half(a_w_r, rd_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_half_bits    = out_half_r;
  assign out_out_of_range = out_oor_r;

endmodule

`default_nettype wire

FILE: hdl/bsfd_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module bsfd_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_half_bits,
  input wire logic        out_out_of_range
);

  // Held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_half_bits)
                               && $stable(out_out_of_range))
    else $error("result changed while stalled");

  // Out-of-range entry gives zero
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_half_bits == 16'd0)
    else $error("out-of-range result not zero");

  // A blocked result stalls the input side
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result blocked");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind block_scaled_fp8_dequant_fp16_core bsfd_chk u_bsfd_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_half_bits(out_half_bits),
  .out_out_of_range(out_out_of_range)
);

`default_nettype wire
